// File: sv/wsd_pkg.sv
`default_nettype none
package wsd_pkg;

  localparam int PhaseW = 3;

  localparam logic [PhaseW-1:0] PH_HDR0    = 3'd0;
  localparam logic [PhaseW-1:0] PH_HDR1    = 3'd1;
  localparam logic [PhaseW-1:0] PH_EXTLEN  = 3'd2;
  localparam logic [PhaseW-1:0] PH_MASK    = 3'd3;
  localparam logic [PhaseW-1:0] PH_PAYLOAD = 3'd4;
  localparam logic [PhaseW-1:0] PH_CLOSED  = 3'd5;

  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [2:0] EXT16_BYTES_M1 = 3'd1;
  localparam logic [2:0] EXT64_BYTES_M1 = 3'd7;
  localparam logic [2:0] KEY_BYTES_M1   = 3'd3;

  localparam logic [1:0] EV_TEXT  = 2'd0;
  localparam logic [1:0] EV_PONG  = 2'd1;
  localparam logic [1:0] EV_CLOSE = 2'd2;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] payload_byte;
    logic       last_of_message;
  } wsd_event_t;

endpackage
`default_nettype wire

// File: sv/wsd_byte_if.sv
`default_nettype none
interface wsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// File: sv/wsd_event_if.sv
`default_nettype none
interface wsd_event_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] payload_byte;
  logic       last_of_message;

  modport source (output valid, output event_kind, output payload_byte,
                  output last_of_message, input ready);
  modport sink (input valid, input event_kind, input payload_byte,
                input last_of_message, output ready);
endinterface
`default_nettype wire

// File: sv/wsd_parser.sv
`default_nettype none
module wsd_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire logic [7:0]        rx_byte,
  output logic                   res_valid,
  output wsd_pkg::wsd_event_t    res
);
  import wsd_pkg::*;

  logic [PhaseW-1:0] phase, phase_next;
  logic [3:0]        frame_opcode, frame_opcode_next;
  logic              mask_present, mask_present_next;
  logic [63:0]       remaining_length, remaining_length_next;
  logic [2:0]        header_byte_count, header_byte_count_next;
  logic [31:0]       mask_key, mask_key_next;
  logic [1:0]        mask_position, mask_position_next;

  logic [63:0]       len_shift;
  logic [63:0]       len_dec;
  logic [6:0]        len7;
  logic [7:0]        key_byte;
  logic [7:0]        data;
  logic              fin_valid;
  logic [1:0]        fin_kind;
  logic [PhaseW-1:0] fin_phase;

  // frame end: close locks up, ping asks for a pong
  always_comb begin
    fin_valid = 1'b0;
    fin_kind  = EV_TEXT;
    fin_phase = PH_HDR0;
    if (frame_opcode == OP_CLOSE) begin
      fin_valid = 1'b1;
      fin_kind  = EV_CLOSE;
      fin_phase = PH_CLOSED;
    end else if (frame_opcode == OP_PING) begin
      fin_valid = 1'b1;
      fin_kind  = EV_PONG;
    end
  end

  always_comb begin
    case (mask_position)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  assign len7      = rx_byte[6:0];
  assign len_shift = {remaining_length[55:0], rx_byte};
  assign len_dec   = remaining_length - 64'd1;
  assign data      = mask_present ? (rx_byte ^ key_byte) : rx_byte;

  always_comb begin
    phase_next             = phase;
    frame_opcode_next      = frame_opcode;
    mask_present_next      = mask_present;
    remaining_length_next  = remaining_length;
    header_byte_count_next = header_byte_count;
    mask_key_next          = mask_key;
    mask_position_next     = mask_position;
    res_valid              = 1'b0;
    res                    = '0;

    case (phase)
      PH_CLOSED: begin
      end
      PH_HDR1: begin
        mask_present_next = rx_byte[7];
        if (len7 == LEN_EXT16) begin
          phase_next             = PH_EXTLEN;
          header_byte_count_next = EXT16_BYTES_M1;
          remaining_length_next  = '0;
        end else if (len7 == LEN_EXT64) begin
          phase_next             = PH_EXTLEN;
          header_byte_count_next = EXT64_BYTES_M1;
          remaining_length_next  = '0;
        end else begin
          remaining_length_next = {57'd0, len7};
          if (rx_byte[7]) begin
            phase_next             = PH_MASK;
            header_byte_count_next = KEY_BYTES_M1;
            mask_key_next          = '0;
          end else begin
            mask_position_next = '0;
            if (len7 == 7'd0) begin
              phase_next       = fin_phase;
              res_valid        = fin_valid;
              res.event_kind   = fin_kind;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
        end
      end
      PH_EXTLEN: begin
        remaining_length_next = len_shift;
        if (header_byte_count == 3'd0) begin
          if (mask_present) begin
            phase_next             = PH_MASK;
            header_byte_count_next = KEY_BYTES_M1;
            mask_key_next          = '0;
          end else begin
            mask_position_next = '0;
            if (len_shift == 64'd0) begin
              phase_next     = fin_phase;
              res_valid      = fin_valid;
              res.event_kind = fin_kind;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
        end else begin
          header_byte_count_next = header_byte_count - 3'd1;
        end
      end
      PH_MASK: begin
        mask_key_next = {mask_key[23:0], rx_byte};
        if (header_byte_count == 3'd0) begin
          mask_position_next = '0;
          if (remaining_length == 64'd0) begin
            phase_next     = fin_phase;
            res_valid      = fin_valid;
            res.event_kind = fin_kind;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end else begin
          header_byte_count_next = header_byte_count - 3'd1;
        end
      end
      PH_PAYLOAD: begin
        mask_position_next    = mask_position + 2'd1;
        remaining_length_next = len_dec;
        if (frame_opcode == OP_TEXT) begin
          res_valid           = 1'b1;
          res.event_kind      = EV_TEXT;
          res.payload_byte    = data;
          res.last_of_message = (len_dec == 64'd0);
          if (len_dec == 64'd0) begin
            phase_next = PH_HDR0;
          end
        end else if (len_dec == 64'd0) begin
          phase_next     = fin_phase;
          res_valid      = fin_valid;
          res.event_kind = fin_kind;
        end
      end
      default: begin
        frame_opcode_next = rx_byte[3:0];
        phase_next        = PH_HDR1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HDR0;
      frame_opcode      <= '0;
      mask_present      <= 1'b0;
      remaining_length  <= '0;
      header_byte_count <= '0;
      mask_key          <= '0;
      mask_position     <= '0;
    end else if (take) begin
      phase             <= phase_next;
      frame_opcode      <= frame_opcode_next;
      mask_present      <= mask_present_next;
      remaining_length  <= remaining_length_next;
      header_byte_count <= header_byte_count_next;
      mask_key          <= mask_key_next;
      mask_position     <= mask_position_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/wsd_out_reg.sv
`default_nettype none
module wsd_out_reg (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire wsd_pkg::wsd_event_t load_data,
  output logic                     space,
  wsd_event_if.source              events
);
  import wsd_pkg::*;

  logic       full;
  wsd_event_t held;

  assign space = !full || events.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (events.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= load_data;
    end
  end

  assign events.valid           = full;
  assign events.event_kind      = held.event_kind;
  assign events.payload_byte    = held.payload_byte;
  assign events.last_of_message = held.last_of_message;

endmodule
`default_nettype wire

// File: sv/websocket_frame_deframer.sv
// WebSocket receive-side deframer. One byte of the framed stream is taken per beat on rx and
// parsed combinationally: header, 16/64-bit extended length, optional mask key, then payload.
// Text payload bytes leave unmasked on events with the final byte of each frame marked; a ping
// frame yields a pong request, a close frame yields a close event after which all bytes are
// swallowed until reset. Binary, continuation, pong and reserved frames are dropped. A new byte
// is accepted every cycle while the single output register is empty or being drained; results
// appear in the cycle after their byte is taken, and a stalled events sink stalls rx only once
// that register holds an untaken beat. FIN and RSV bits are not checked.
`default_nettype none
module websocket_frame_deframer (
  input  wire logic   clk,
  input  wire logic   rst,
  wsd_byte_if.sink    rx,
  wsd_event_if.source events
);
  import wsd_pkg::*;

  logic       take;
  logic       space;
  logic       res_valid;
  wsd_event_t res;

  assign rx.ready = space;
  assign take     = rx.valid && space;

  wsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .rx_byte   (rx.rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  wsd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (take && res_valid),
    .load_data (res),
    .space     (space),
    .events    (events)
  );

endmodule
`default_nettype wire

// File: dv/websocket_frame_deframer_test.sv
`timescale 1ns / 1ps
module websocket_frame_deframer_test;
  import wsd_pkg::*;

  localparam logic [3:0] OP_CONT      = 4'h0;
  localparam logic [3:0] OP_BINARY    = 4'h2;
  localparam logic [3:0] OP_RSVD_DATA = 4'h3;
  localparam logic [3:0] OP_PONG      = 4'hA;
  localparam logic [3:0] OP_RSVD_CTRL = 4'hB;

  localparam int LEN_FORM_7  = 0;
  localparam int LEN_FORM_16 = 1;
  localparam int LEN_FORM_64 = 2;

  localparam int RANDOM_FILL = -1;

  logic clk;
  logic rst;

  wsd_byte_if  rx_if ();
  wsd_event_if ev_if ();

  websocket_frame_deframer dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_if),
    .events (ev_if)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  logic [7:0] tx_bytes[$];
  wsd_event_t events_due[$];
  int         bytes_queued;
  int         errors;
  int         events_seen;

  // parser shadow state
  logic [2:0]  ph;
  logic [3:0]  opcode;
  logic        masked;
  logic [63:0] len_left;
  logic [2:0]  hdr_left;
  logic [31:0] key;
  logic [1:0]  key_idx;

  task automatic frame_end();
    if (opcode == OP_CLOSE) begin
      ph = PH_CLOSED;
      events_due.push_back(wsd_event_t'{EV_CLOSE, 8'h00, 1'b0});
    end else begin
      ph = PH_HDR0;
      if (opcode == OP_PING) events_due.push_back(wsd_event_t'{EV_PONG, 8'h00, 1'b0});
    end
  endtask

  task automatic header_end();
    key_idx = 2'd0;
    if (len_left == 64'd0) frame_end();
    else ph = PH_PAYLOAD;
  endtask

  task automatic length_end();
    if (masked) begin
      ph = PH_MASK;
      hdr_left = KEY_BYTES_M1;
      key = 32'h0;
    end else begin
      header_end();
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] d;
    case (ph)
      PH_CLOSED: begin
      end
      PH_HDR1: begin
        masked = b[7];
        if (b[6:0] == LEN_EXT16) begin
          ph = PH_EXTLEN;
          hdr_left = EXT16_BYTES_M1;
          len_left = 64'd0;
        end else if (b[6:0] == LEN_EXT64) begin
          ph = PH_EXTLEN;
          hdr_left = EXT64_BYTES_M1;
          len_left = 64'd0;
        end else begin
          len_left = {57'd0, b[6:0]};
          length_end();
        end
      end
      PH_EXTLEN: begin
        len_left = {len_left[55:0], b};
        if (hdr_left == 3'd0) length_end();
        else hdr_left = hdr_left - 3'd1;
      end
      PH_MASK: begin
        key = {key[23:0], b};
        if (hdr_left == 3'd0) header_end();
        else hdr_left = hdr_left - 3'd1;
      end
      PH_PAYLOAD: begin
        d = b;
        if (masked) d = d ^ key[8 * (3 - key_idx) +: 8];
        key_idx = key_idx + 2'd1;
        len_left = len_left - 64'd1;
        if (opcode == OP_TEXT) begin
          events_due.push_back(wsd_event_t'{EV_TEXT, d, len_left == 64'd0});
          if (len_left == 64'd0) ph = PH_HDR0;
        end else if (len_left == 64'd0) begin
          frame_end();
        end
      end
      default: begin
        opcode = b[3:0];
        ph = PH_HDR1;
      end
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b);
    tx_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic add_frame(input logic [3:0] op, input logic mask_on, input int len,
                           input int form, input int fill);
    logic [63:0] len64;
    logic [3:0]  flags;
    logic [7:0]  r;
    len64 = 64'(len);
    flags = 4'($urandom_range(0, 15));
    push_byte({flags, op});
    case (form)
      LEN_FORM_7: begin
        push_byte({mask_on, len64[6:0]});
      end
      LEN_FORM_16: begin
        push_byte({mask_on, LEN_EXT16});
        push_byte(len64[15:8]);
        push_byte(len64[7:0]);
      end
      default: begin
        push_byte({mask_on, LEN_EXT64});
        for (int i = 7; i >= 0; i--) push_byte(len64[8 * i +: 8]);
      end
    endcase
    if (mask_on) begin
      for (int i = 0; i < 4; i++) begin
        r = 8'($urandom_range(0, 255));
        push_byte(r);
      end
    end
    for (int i = 0; i < len; i++) begin
      r = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
      push_byte(r);
    end
  endtask

  initial begin
    rx_if.valid = 1'b0;
    rx_if.rx_byte = 8'h00;
    ev_if.ready = 1'b0;
    ph = PH_HDR0;
    opcode = 4'h0;
    masked = 1'b0;
    len_left = 64'd0;
    hdr_left = 3'd0;
    key = 32'h0;
    key_idx = 2'd0;
    errors = 0;
    events_seen = 0;
    bytes_queued = 0;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  // sender: bursts and gaps
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (rst) begin
      rx_if.valid <= 1'b0;
      rx_if.rx_byte <= 8'h00;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (rx_if.valid && rx_if.ready) begin
        deframe_byte(rx_if.rx_byte);
        void'(tx_bytes.pop_front());
      end
      if (rx_if.valid && !rx_if.ready) begin
        // beat still pending, hold it
      end else if (tx_bytes.size() != 0 && gap_left == 0) begin
        rx_if.valid <= 1'b1;
        rx_if.rx_byte <= tx_bytes[0];
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        rx_if.valid <= 1'b0;
        if (gap_left != 0) gap_left--;
      end
    end
  end

  // receiver: random stall pattern plus one long hold-off
  int  mode_left;
  bit  stall_mode;
  int  hold_left;
  bit  hold_done;

  always @(posedge clk) begin
    if (rst) begin
      ev_if.ready <= 1'b0;
      mode_left = 0;
      stall_mode = 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      ev_if.ready <= 1'b0;
    end else if (!hold_done && events_seen >= 150) begin
      hold_done = 1'b1;
      hold_left = 400;
      ev_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(8, 80);
        stall_mode = ($urandom_range(0, 2) != 0);
      end else begin
        mode_left--;
      end
      ev_if.ready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
    end
  end

  wsd_event_t want;

  always @(posedge clk) begin
    if (!rst && ev_if.valid && ev_if.ready) begin
      events_seen++;
      if (events_due.size() == 0) begin
        $error("unexpected event: event_kind %0d payload_byte %02h last_of_message %0d",
               ev_if.event_kind, ev_if.payload_byte, ev_if.last_of_message);
        errors++;
      end else begin
        want = events_due.pop_front();
        if (ev_if.event_kind !== want.event_kind) begin
          $error("event_kind: expected %0d, got %0d", want.event_kind, ev_if.event_kind);
          errors++;
        end
        if (ev_if.payload_byte !== want.payload_byte) begin
          $error("payload_byte: expected %02h, got %02h", want.payload_byte,
                 ev_if.payload_byte);
          errors++;
        end
        if (ev_if.last_of_message !== want.last_of_message) begin
          $error("last_of_message: expected %0d, got %0d", want.last_of_message,
                 ev_if.last_of_message);
          errors++;
        end
      end
    end
  end

  initial begin
    int         pick;
    int         len;
    int         form;
    int         v;
    logic [3:0] op;
    logic       mask_on;
    logic [7:0] r;

    // empty frames, masked extremes, 16-bit length, ping with payload
    add_frame(OP_TEXT, 1'b0, 0, LEN_FORM_7, RANDOM_FILL);
    add_frame(OP_PING, 1'b0, 0, LEN_FORM_7, RANDOM_FILL);
    add_frame(OP_TEXT, 1'b1, 2, LEN_FORM_7, 8'hFF);
    add_frame(OP_TEXT, 1'b0, 2, LEN_FORM_16, 8'h00);
    add_frame(OP_PING, 1'b1, 1, LEN_FORM_7, RANDOM_FILL);

    // let everything drain before the random part
    do @(posedge clk);
    while (tx_bytes.size() != 0 || rx_if.valid || events_due.size() != 0);

    while (bytes_queued < 1600) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) op = OP_TEXT;
      else if (pick < 65) op = OP_PING;
      else if (pick < 75) op = OP_BINARY;
      else if (pick < 80) op = OP_CONT;
      else if (pick < 85) op = OP_PONG;
      else begin
        v = $urandom_range(0, 9);
        op = (v < 5) ? OP_RSVD_DATA + 4'(v) : OP_RSVD_CTRL + 4'(v - 5);
      end
      mask_on = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 19);
      if (pick < 14) len = $urandom_range(0, 12);
      else if (pick < 18) len = $urandom_range(13, 125);
      else len = $urandom_range(126, 300);
      if (len >= 126 || $urandom_range(0, 5) == 0)
        form = $urandom_range(0, 1) ? LEN_FORM_16 : LEN_FORM_64;
      else
        form = LEN_FORM_7;
      add_frame(op, mask_on, len, form, RANDOM_FILL);
    end

    // close ends the stream; trailing bytes must be swallowed
    mask_on = 1'($urandom_range(0, 1));
    add_frame(OP_CLOSE, mask_on, 0, LEN_FORM_7, RANDOM_FILL);
    for (int i = 0; i < 12; i++) begin
      r = 8'($urandom_range(0, 255));
      push_byte(r);
    end

    do @(posedge clk);
    while (tx_bytes.size() != 0 || rx_if.valid || events_due.size() != 0);
    repeat (16) @(posedge clk);

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: websocket_frame_deframer.f
sv/wsd_pkg.sv
sv/wsd_byte_if.sv
sv/wsd_event_if.sv
sv/wsd_parser.sv
sv/wsd_out_reg.sv
sv/websocket_frame_deframer.sv
dv/websocket_frame_deframer_test.sv
